FILE: rtl/b64dec_pkg.sv
// Shared types, codes and the character-to-sextet table of the base64 stream decoder.
package b64dec_pkg;

    // Result-group queue between the decode step and the output serializer
    localparam int unsigned GRP_DEPTH = 4;
    localparam int unsigned GRP_PTR_W = $clog2(GRP_DEPTH);
    localparam int unsigned GRP_CNT_W = $clog2(GRP_DEPTH + 1);

    // Bit value of a sextet that is not in the alphabet
    localparam logic [6:0] SEXTET_NONE = 7'd64;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CH_LOA   = 8'h61;
    localparam logic [7:0] CH_LOZ   = 8'h7A;

    // Status codes carried on the last result of an item
    localparam logic [1:0] STAT_RUNNING  = 2'd0;
    localparam logic [1:0] STAT_OK       = 2'd1;
    localparam logic [1:0] STAT_BAD_CHAR = 2'd2;
    localparam logic [1:0] STAT_MID_GRP  = 2'd3;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_RUN   = 2'd1,
        PH_DRAIN = 2'd2
    } phase_t;

    // All results caused by one input item
    typedef struct packed {
        logic [2:0][7:0] bytes;     // bytes[0] goes out first
        logic [1:0]      n_bytes;   // 0 to 3 decoded bytes
        logic [1:0]      status;
    } res_grp_t;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = SEXTET_NONE;
        if (c >= CH_UPA && c <= CH_UPZ)
        begin
            v = 7'(c - CH_UPA);
        end
        else if (c >= CH_LOA && c <= CH_LOZ)
        begin
            v = 7'(c - CH_LOA + 8'd26);
        end
        else if (c >= CH_DIG0 && c <= CH_DIG9)
        begin
            v = 7'(c - CH_DIG0 + 8'd52);
        end
        else if (c == CH_PLUS)
        begin
            v = 7'd62;
        end
        else if (c == CH_SLASH)
        begin
            v = 7'd63;
        end
        return v;
    endfunction

    function automatic logic is_lead_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

FILE: rtl/b64dec_step.sv
// Decode state and the per-character step that turns one item into a result group.
module b64dec_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          in_char,
    input  logic                end_of_stream,
    output b64dec_pkg::res_grp_t grp
);

    b64dec_pkg::phase_t phase_reg, phase_next;
    logic [1:0]         slot_reg, slot_next;
    logic [23:0]        bits_reg, bits_next;
    logic               saw_nl_reg, saw_nl_next;

    logic [6:0]         sextet;
    logic [23:0]        merged;
    logic               ph_run;

    assign sextet = b64dec_pkg::sextet_of(in_char);
    assign ph_run = (phase_reg == b64dec_pkg::PH_RUN);

    always_comb
    begin
        merged = bits_reg;
        case (slot_reg)
            2'd0: merged[23:18] = bits_reg[23:18] | sextet[5:0];
            2'd1: merged[17:12] = bits_reg[17:12] | sextet[5:0];
            2'd2: merged[11:6]  = bits_reg[11:6]  | sextet[5:0];
            default: merged[5:0] = bits_reg[5:0] | sextet[5:0];
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        slot_next    = slot_reg;
        bits_next    = bits_reg;
        saw_nl_next  = saw_nl_reg;
        grp.bytes    = '0;
        grp.n_bytes  = 2'd0;
        grp.status   = b64dec_pkg::STAT_RUNNING;

        if (end_of_stream)
        begin
            grp.status  = (ph_run && slot_reg != 2'd0) ? b64dec_pkg::STAT_MID_GRP
                                                       : b64dec_pkg::STAT_OK;
            phase_next  = b64dec_pkg::PH_SKIP;
            slot_next   = 2'd0;
            bits_next   = '0;
            saw_nl_next = 1'b0;
        end
        else if (phase_reg == b64dec_pkg::PH_DRAIN)
        begin
            if (in_char == b64dec_pkg::CH_SPACE || in_char == b64dec_pkg::CH_TAB ||
                in_char == b64dec_pkg::CH_LF)
            begin
                phase_next = b64dec_pkg::PH_SKIP;
            end
        end
        else if (!ph_run && b64dec_pkg::is_lead_space(in_char))
        begin
            // hold: leading whitespace
        end
        else
        begin
            phase_next = b64dec_pkg::PH_RUN;
            if (in_char == b64dec_pkg::CH_LF)
            begin
                if (saw_nl_reg)
                begin
                    // blank line ends the message, partial group dropped
                    grp.status  = b64dec_pkg::STAT_OK;
                    phase_next  = b64dec_pkg::PH_SKIP;
                    slot_next   = 2'd0;
                    bits_next   = '0;
                    saw_nl_next = 1'b0;
                end
                else
                begin
                    saw_nl_next = 1'b1;
                end
            end
            else if (in_char == b64dec_pkg::CH_CR)
            begin
                // drop
            end
            else if (in_char == b64dec_pkg::CH_PAD)
            begin
                if (slot_reg == 2'd2 || slot_reg == 2'd3)
                begin
                    grp.bytes[0] = bits_reg[23:16];
                    grp.bytes[1] = bits_reg[15:8];
                    grp.n_bytes  = (slot_reg == 2'd2) ? 2'd1 : 2'd2;
                    grp.status   = b64dec_pkg::STAT_OK;
                    phase_next   = b64dec_pkg::PH_DRAIN;
                    slot_next    = 2'd0;
                    bits_next    = '0;
                    saw_nl_next  = 1'b0;
                end
                else
                begin
                    slot_next = slot_reg + 2'd1;
                end
            end
            else if (sextet == b64dec_pkg::SEXTET_NONE)
            begin
                grp.status  = b64dec_pkg::STAT_BAD_CHAR;
                phase_next  = b64dec_pkg::PH_SKIP;
                slot_next   = 2'd0;
                bits_next   = '0;
                saw_nl_next = 1'b0;
            end
            else
            begin
                saw_nl_next = 1'b0;
                if (slot_reg == 2'd3)
                begin
                    grp.bytes[0] = merged[23:16];
                    grp.bytes[1] = merged[15:8];
                    grp.bytes[2] = merged[7:0];
                    grp.n_bytes  = 2'd3;
                    bits_next    = '0;
                    slot_next    = 2'd0;
                end
                else
                begin
                    bits_next = merged;
                    slot_next = slot_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= b64dec_pkg::PH_SKIP;
            slot_reg   <= 2'd0;
            bits_reg   <= '0;
            saw_nl_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            slot_reg   <= slot_next;
            bits_reg   <= bits_next;
            saw_nl_reg <= saw_nl_next;
        end
    end

endmodule

FILE: rtl/b64dec_out_queue.sv
// Result-group queue and the serializer that sends each group out one result per transfer.
module b64dec_out_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  b64dec_pkg::res_grp_t grp,
    output logic                 full,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,
    output logic [2:0]           m_axis_tuser,
    output logic                 m_axis_tlast
);

    b64dec_pkg::res_grp_t                  grp_reg [b64dec_pkg::GRP_DEPTH];
    logic [b64dec_pkg::GRP_PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [b64dec_pkg::GRP_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [1:0]                            idx_reg;

    b64dec_pkg::res_grp_t                  head;
    logic                                  is_last;
    logic                                  xfer;
    logic                                  pop;

    assign head          = grp_reg[rd_ptr_reg];
    assign full          = (cnt_reg == b64dec_pkg::GRP_CNT_W'(b64dec_pkg::GRP_DEPTH));
    assign m_axis_tvalid = (cnt_reg != '0);
    assign is_last       = (head.n_bytes == 2'd0) || (idx_reg == head.n_bytes - 2'd1);
    assign xfer          = m_axis_tvalid && m_axis_tready;
    assign pop           = xfer && is_last;

    always_comb
    begin
        m_axis_tdata    = '0;
        m_axis_tuser    = '0;
        if (head.n_bytes != 2'd0)
        begin
            m_axis_tdata    = head.bytes[idx_reg];
            m_axis_tuser[0] = 1'b1;
        end
        m_axis_tuser[2:1] = is_last ? head.status : b64dec_pkg::STAT_RUNNING;
        m_axis_tlast      = is_last;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + b64dec_pkg::GRP_CNT_W'(1);
        end
        else if (!push && pop)
        begin
            cnt_next = cnt_reg - b64dec_pkg::GRP_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            grp_reg[wr_ptr_reg] <= grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + b64dec_pkg::GRP_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + b64dec_pkg::GRP_PTR_W'(1);
                idx_reg    <= 2'd0;
            end
            else if (xfer)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

FILE: rtl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: input register, decode step and result queue.
//
//  channel  | dir | payload                                      | ends with
//  s_axis   | in  | tdata[7:0] in_char, tuser[0] end_of_stream   | -
//  m_axis   | out | tdata[7:0] data_byte,                         | tlast = last
//           |     | tuser[0] data_valid, tuser[2:1] status       |
//
// One character a cycle is taken in when not stalled; it is decoded from the input
// register into a four-deep queue of result groups. A group yields one to three output
// transfers, one per cycle while tready is high, so the output side sets the sustained
// rate when it carries more than one result per character. Input stalls only when the
// input register is full and the group queue is full. Reset clears the decode state, the
// input register and the queue; no item is lost or repeated under stalls on either side.
module base64_stream_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_char
    input  logic       s_axis_tuser,    // [0] end_of_stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] data_byte
    output logic [2:0] m_axis_tuser,    // [0] data_valid, [2:1] status
    output logic       m_axis_tlast
);

    logic                 in_valid_reg;
    logic [7:0]           in_char_reg;
    logic                 in_eos_reg;

    logic                 q_full;
    logic                 fire;
    b64dec_pkg::res_grp_t grp;

    assign fire          = in_valid_reg && !q_full;
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // hold the payload until the decode step takes it
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_eos_reg  <= s_axis_tuser;
        end
    end

    b64dec_step u_step
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .in_char       (in_char_reg),
        .end_of_stream (in_eos_reg),
        .grp           (grp)
    );

    b64dec_out_queue u_out_queue
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (fire),
        .grp           (grp),
        .full          (q_full),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
